/* rtl/itop_pkg.sv */
// shared types, constants and register codes for the inverse-time overload protector
`default_nettype none

package itop_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // field widths
  localparam int LIMIT_W   = 17;
  localparam int SEVERE_W  = 16;
  localparam int STEP_W    = 10;
  localparam int HOLD_W    = 9;
  localparam int OUT_LVL_W = 3;
  localparam int INV_LVL_W = 5;
  localparam int COUNT_W   = 17;

  // default accumulator width
  localparam int DELAY_BITS_DEF = 17;

  // register reset values
  localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RST    = 17'd91500;
  localparam logic [SEVERE_W-1:0] SEVERE_INCREMENT_RST = 16'd30600;
  localparam logic [STEP_W-1:0]   MEDIUM_INCREMENT_RST = 10'd60;
  localparam logic [STEP_W-1:0]   LIGHT_INCREMENT_RST  = 10'd12;
  localparam logic [STEP_W-1:0]   DECAY_STEP_RST       = 10'd60;
  localparam logic [HOLD_W-1:0]   TIMEOUT_HOLD_RST     = 9'd400;
  localparam logic [HOLD_W-1:0]   IMPACT_HOLD_RST      = 9'd20;

  // confirmation thresholds
  localparam logic [3:0] HIGH_CONFIRM_MAX = 4'd6;
  localparam logic [4:0] OVL_CONFIRM_MAX  = 5'd8;

  // load level codes
  localparam logic [OUT_LVL_W-1:0] OUT_LVL_ALL = 3'd7;
  localparam logic [INV_LVL_W-1:0] INV_LVL_OVL = 5'd2;
  localparam logic [INV_LVL_W-1:0] INV_LVL_MED = 5'd15;
  localparam logic [INV_LVL_W-1:0] INV_LVL_SEV = 5'd31;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_LIMIT    = 3'd0,
    REG_SEVERE_INCREMENT = 3'd1,
    REG_MEDIUM_INCREMENT = 3'd2,
    REG_LIGHT_INCREMENT  = 3'd3,
    REG_DECAY_STEP       = 3'd4,
    REG_TIMEOUT_HOLD     = 3'd5,
    REG_IMPACT_HOLD      = 3'd6
  } cfg_reg_t;

  // configuration set
  typedef struct packed {
    logic [LIMIT_W-1:0]  timeout_limit;
    logic [SEVERE_W-1:0] severe_increment;
    logic [STEP_W-1:0]   medium_increment;
    logic [STEP_W-1:0]   light_increment;
    logic [STEP_W-1:0]   decay_step;
    logic [HOLD_W-1:0]   timeout_hold;
    logic [HOLD_W-1:0]   impact_hold;
  } cfg_t;

  // one input beat
  typedef struct packed {
    logic                 tick_40ms;
    logic                 on_inverter;
    logic                 bypass_switch_closed;
    logic [OUT_LVL_W-1:0] output_load_level;
    logic [INV_LVL_W-1:0] inverter_load_level;
    logic                 short_circuit;
    logic                 impact_ready;
  } item_t;

  // one result beat
  typedef struct packed {
    logic               overload_signal;
    logic               overload_flag;
    logic               output_high_flag;
    logic               timeout_flag;
    logic               impact_flag;
    logic [COUNT_W-1:0] delay_count;
  } result_t;

endpackage

`default_nettype wire

/* rtl/itop_state.sv */
// protection state registers and their per-beat update
`default_nettype none

module itop_state #(
  parameter int DELAY_BITS = itop_pkg::DELAY_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  itop_pkg::item_t      item,
  input  itop_pkg::cfg_t       cfg,
  output itop_pkg::result_t    result
);

  // wide enough for accumulator plus any increment and for the limit
  localparam int W = ((DELAY_BITS > itop_pkg::LIMIT_W) ? DELAY_BITS : itop_pkg::LIMIT_W) + 1;

  logic                          high_flag_r, high_flag_nxt;
  logic [2:0]                    high_cnt_r, high_cnt_nxt;
  logic                          ovl_r, ovl_nxt;
  logic [3:0]                    ovl_cnt_r, ovl_cnt_nxt;
  logic [DELAY_BITS-1:0]         acc_r, acc_nxt;
  logic                          timeout_r, timeout_nxt;
  logic                          impact_r, impact_nxt;
  logic [itop_pkg::HOLD_W-1:0]   hold_r, hold_nxt;
  logic                          signal;

  logic [3:0]  high_sum;
  logic [4:0]  ovl_sum;
  logic [W-1:0] acc_w, mask_w, limit_w, tl_w, add_w, dec_w, sum_w;
  logic [W-1:0] acc_nxt_w;
  logic         sc;
  logic [itop_pkg::INV_LVL_W-1:0] inv_lvl;

  assign sc      = item.short_circuit;
  assign inv_lvl = item.inverter_load_level;
  assign acc_w   = {{(W-DELAY_BITS){1'b0}}, acc_r};
  assign mask_w  = {{(W-DELAY_BITS){1'b0}}, {DELAY_BITS{1'b1}}};
  assign tl_w    = {{(W-itop_pkg::LIMIT_W){1'b0}}, cfg.timeout_limit};
  assign limit_w = (tl_w < mask_w) ? tl_w : mask_w;
  assign dec_w   = {{(W-itop_pkg::STEP_W){1'b0}}, cfg.decay_step};
  assign high_sum = {1'b0, high_cnt_r} + 4'd2;
  assign ovl_sum  = {1'b0, ovl_cnt_r} + (sc ? 5'd3 : 5'd2);

  // accumulator increment by severity
  always_comb begin
    if (inv_lvl == itop_pkg::INV_LVL_SEV || sc) begin
      add_w = {{(W-itop_pkg::SEVERE_W){1'b0}}, cfg.severe_increment};
    end else if (inv_lvl == itop_pkg::INV_LVL_MED) begin
      add_w = {{(W-itop_pkg::STEP_W){1'b0}}, cfg.medium_increment};
    end else begin
      add_w = {{(W-itop_pkg::STEP_W){1'b0}}, cfg.light_increment};
    end
  end
  assign sum_w = acc_w + add_w;

  // output-high confirmation
  always_comb begin
    high_flag_nxt = high_flag_r;
    high_cnt_nxt  = high_cnt_r;
    if (item.tick_40ms) begin
      if (high_flag_r) begin
        if (item.output_load_level == '0 && !sc) begin
          high_flag_nxt = 1'b0;
          high_cnt_nxt  = '0;
        end
      end else if (item.output_load_level == itop_pkg::OUT_LVL_ALL || sc) begin
        if (high_sum >= itop_pkg::HIGH_CONFIRM_MAX) begin
          high_flag_nxt = 1'b1;
          high_cnt_nxt  = itop_pkg::HIGH_CONFIRM_MAX[2:0];
        end else begin
          high_cnt_nxt  = high_sum[2:0];
        end
      end else begin
        high_cnt_nxt = '0;
      end
    end
  end

  // inverter overload confirmation
  always_comb begin
    ovl_nxt     = ovl_r;
    ovl_cnt_nxt = ovl_cnt_r;
    if (item.on_inverter) begin
      if (item.tick_40ms) begin
        if (ovl_r) begin
          if (inv_lvl == '0 && !sc) begin
            ovl_nxt     = 1'b0;
            ovl_cnt_nxt = '0;
          end
        end else if (inv_lvl > itop_pkg::INV_LVL_OVL || sc) begin
          if (ovl_sum >= itop_pkg::OVL_CONFIRM_MAX) begin
            ovl_nxt     = 1'b1;
            ovl_cnt_nxt = itop_pkg::OVL_CONFIRM_MAX[3:0];
          end else begin
            ovl_cnt_nxt = ovl_sum[3:0];
          end
        end else begin
          ovl_cnt_nxt = '0;
        end
      end
    end else begin
      ovl_cnt_nxt = '0;
      ovl_nxt     = item.bypass_switch_closed ? high_flag_nxt : 1'b0;
    end
  end

  // inverse-time accumulator, timeout and impact request
  always_comb begin
    acc_nxt     = acc_r;
    timeout_nxt = timeout_r;
    impact_nxt  = impact_r;
    if (item.on_inverter) begin
      if (item.tick_40ms) begin
        if (!ovl_nxt) begin
          acc_nxt = (acc_w > dec_w) ? acc_r - dec_w[DELAY_BITS-1:0] : '0;
        end else if (sum_w >= limit_w) begin
          timeout_nxt = 1'b1;
          acc_nxt     = limit_w[DELAY_BITS-1:0];
        end else begin
          acc_nxt = sum_w[DELAY_BITS-1:0];
        end
      end
      if (item.impact_ready) begin
        impact_nxt = 1'b1;
      end
    end else begin
      timeout_nxt = 1'b0;
      acc_nxt     = '0;
      impact_nxt  = 1'b0;
    end
  end

  // bus signal with hold, timeout first
  always_comb begin
    hold_nxt = hold_r;
    signal   = 1'b0;
    if (timeout_nxt) begin
      signal   = 1'b1;
      hold_nxt = cfg.timeout_hold;
    end else if (impact_nxt) begin
      signal   = 1'b1;
      hold_nxt = cfg.impact_hold;
    end else if (hold_r != '0) begin
      signal   = 1'b1;
      hold_nxt = hold_r - {{(itop_pkg::HOLD_W-1){1'b0}}, 1'b1};
    end
  end

  // state update on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_flag_r <= 1'b0;
      high_cnt_r  <= '0;
      ovl_r       <= 1'b0;
      ovl_cnt_r   <= '0;
      acc_r       <= '0;
      timeout_r   <= 1'b0;
      impact_r    <= 1'b0;
      hold_r      <= '0;
    end else if (step) begin
      high_flag_r <= high_flag_nxt;
      high_cnt_r  <= high_cnt_nxt;
      ovl_r       <= ovl_nxt;
      ovl_cnt_r   <= ovl_cnt_nxt;
      acc_r       <= acc_nxt;
      timeout_r   <= timeout_nxt;
      impact_r    <= impact_nxt;
      hold_r      <= hold_nxt;
    end
  end

  // accumulator widened so the reported count can be taken from its low bits
  assign acc_nxt_w = {{(W-DELAY_BITS){1'b0}}, acc_nxt};

  // result of this beat, as seen after the update
  always_comb begin
    result.overload_signal  = signal;
    result.overload_flag    = ovl_nxt;
    result.output_high_flag = high_flag_nxt;
    result.timeout_flag     = timeout_nxt;
    result.impact_flag      = impact_nxt;
    result.delay_count      = acc_nxt_w[itop_pkg::COUNT_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/inverse_time_overload_protector.sv */
// Inverse-time overload protector: takes one control-loop beat per clock
// while in_ready is high and returns one result beat per input beat, in
// order. A beat passes an input register and then a result register, and
// the combinational state update between the two registers loads its result
// into the result register, from which it shows on the out port; the
// sustained rate is one beat per clock while out_ready stays high. Either
// register holds its beat while the next stage stalls, and in_ready drops
// only when both are full and out_ready is low. Configuration writes through
// the cfg port are always taken (cfg_ready is high) and must happen while no
// beat is in flight; writes to an index past the register list are dropped.
`default_nettype none

module inverse_time_overload_protector #(
  parameter int DELAY_BITS = itop_pkg::DELAY_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration write channel
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [itop_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [itop_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_tick_40ms,
  input  wire                                   in_on_inverter,
  input  wire                                   in_bypass_switch_closed,
  input  wire  [itop_pkg::OUT_LVL_W-1:0]        in_output_load_level,
  input  wire  [itop_pkg::INV_LVL_W-1:0]        in_inverter_load_level,
  input  wire                                   in_short_circuit,
  input  wire                                   in_impact_ready,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_overload_signal,
  output logic                                  out_overload_flag,
  output logic                                  out_output_high_flag,
  output logic                                  out_timeout_flag,
  output logic                                  out_impact_flag,
  output logic [itop_pkg::COUNT_W-1:0]          out_delay_count
);

  itop_pkg::cfg_t    cfg_r;
  itop_pkg::item_t   item_r;
  itop_pkg::result_t res_r;
  itop_pkg::result_t res_nxt;
  logic              item_vld_r;
  logic              res_vld_r;
  logic              res_free;
  logic              step;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit    <= itop_pkg::TIMEOUT_LIMIT_RST;
      cfg_r.severe_increment <= itop_pkg::SEVERE_INCREMENT_RST;
      cfg_r.medium_increment <= itop_pkg::MEDIUM_INCREMENT_RST;
      cfg_r.light_increment  <= itop_pkg::LIGHT_INCREMENT_RST;
      cfg_r.decay_step       <= itop_pkg::DECAY_STEP_RST;
      cfg_r.timeout_hold     <= itop_pkg::TIMEOUT_HOLD_RST;
      cfg_r.impact_hold      <= itop_pkg::IMPACT_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (itop_pkg::cfg_reg_t'(cfg_index))
        itop_pkg::REG_TIMEOUT_LIMIT:    cfg_r.timeout_limit    <= cfg_data;
        itop_pkg::REG_SEVERE_INCREMENT: cfg_r.severe_increment <= cfg_data[itop_pkg::SEVERE_W-1:0];
        itop_pkg::REG_MEDIUM_INCREMENT: cfg_r.medium_increment <= cfg_data[itop_pkg::STEP_W-1:0];
        itop_pkg::REG_LIGHT_INCREMENT:  cfg_r.light_increment  <= cfg_data[itop_pkg::STEP_W-1:0];
        itop_pkg::REG_DECAY_STEP:       cfg_r.decay_step       <= cfg_data[itop_pkg::STEP_W-1:0];
        itop_pkg::REG_TIMEOUT_HOLD:     cfg_r.timeout_hold     <= cfg_data[itop_pkg::HOLD_W-1:0];
        itop_pkg::REG_IMPACT_HOLD:      cfg_r.impact_hold      <= cfg_data[itop_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline flow control
  assign res_free = !res_vld_r || out_ready;
  assign step     = item_vld_r && res_free;
  assign in_ready = !item_vld_r || res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (res_free) begin
        res_vld_r <= item_vld_r;
      end
    end
  end

  // input and result payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.tick_40ms            <= in_tick_40ms;
      item_r.on_inverter          <= in_on_inverter;
      item_r.bypass_switch_closed <= in_bypass_switch_closed;
      item_r.output_load_level    <= in_output_load_level;
      item_r.inverter_load_level  <= in_inverter_load_level;
      item_r.short_circuit        <= in_short_circuit;
      item_r.impact_ready         <= in_impact_ready;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  itop_state #(
    .DELAY_BITS (DELAY_BITS)
  ) u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (res_nxt)
  );

  assign out_valid            = res_vld_r;
  assign out_overload_signal  = res_r.overload_signal;
  assign out_overload_flag    = res_r.overload_flag;
  assign out_output_high_flag = res_r.output_high_flag;
  assign out_timeout_flag     = res_r.timeout_flag;
  assign out_impact_flag      = res_r.impact_flag;
  assign out_delay_count      = res_r.delay_count;

endmodule

`default_nettype wire

/* rtl/itop_chk.sv */
// port-level checker for the inverse-time overload protector and its bind
`default_nettype none

module itop_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire                              out_overload_signal,
  input wire                              out_timeout_flag,
  input wire                              out_impact_flag,
  input wire [itop_pkg::COUNT_W-1:0]      out_delay_count
);

  // a timeout always drives the bus signal
  a_timeout_signal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeout_flag |-> out_overload_signal)
    else $error("timeout beat without overload signal");

  // an impact request always drives the bus signal
  a_impact_signal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_impact_flag |-> out_overload_signal)
    else $error("impact beat without overload signal");

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_delay_count)
      && $stable(out_overload_signal))
    else $error("stalled result changed");

  // with the result side empty the input is always open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

endmodule

bind inverse_time_overload_protector itop_chk u_itop_chk (.*);

`default_nettype wire

/* tb/tb_top.sv */
// self-checking bench for the overload protector: random loop beats, register sweeps, in-order check
module tb_top;
  import itop_pkg::*;

  // idling and stall shaping
  localparam int IDLE_PCT          = 25;
  localparam int LONG_HOLD_EVERY   = 400;
  localparam int LONG_HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES      = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_OF_RANGE = 3'd7;

  // run kinds for the random part
  typedef enum int {RUN_OVERLOAD, RUN_RECOVER, RUN_BYPASS, RUN_NOISE} run_kind_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_tick_40ms = 1'b0;
  logic                 in_on_inverter = 1'b0;
  logic                 in_bypass_switch_closed = 1'b0;
  logic [OUT_LVL_W-1:0] in_output_load_level = '0;
  logic [INV_LVL_W-1:0] in_inverter_load_level = '0;
  logic                 in_short_circuit = 1'b0;
  logic                 in_impact_ready = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_overload_signal;
  logic               out_overload_flag;
  logic               out_output_high_flag;
  logic               out_timeout_flag;
  logic               out_impact_flag;
  logic [COUNT_W-1:0] out_delay_count;

  // beats waiting to be sent and results still owed by the block
  item_t   loop_beats_pending[$];
  result_t protection_results_due[$];
  item_t   beat_on_offer = '0;

  // shadow of the protector state and its registers
  cfg_t        prot_cfg = '{TIMEOUT_LIMIT_RST, SEVERE_INCREMENT_RST, MEDIUM_INCREMENT_RST,
                            LIGHT_INCREMENT_RST, DECAY_STEP_RST, TIMEOUT_HOLD_RST,
                            IMPACT_HOLD_RST};
  logic        prot_high = 1'b0;
  int          prot_high_cnt = 0;
  logic        prot_ovl = 1'b0;
  int          prot_ovl_cnt = 0;
  int unsigned prot_delay = 0;
  logic        prot_timeout = 1'b0;
  logic        prot_impact = 1'b0;
  int unsigned prot_hold = 0;

  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  int mismatches = 0;
  int results_checked = 0;
  int settings_used = 1;
  int timeouts_seen = 0;
  int impacts_seen = 0;
  int held_seen = 0;
  int ready_hold_left = 0;

  inverse_time_overload_protector i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_tick_40ms            (in_tick_40ms),
    .in_on_inverter          (in_on_inverter),
    .in_bypass_switch_closed (in_bypass_switch_closed),
    .in_output_load_level    (in_output_load_level),
    .in_inverter_load_level  (in_inverter_load_level),
    .in_short_circuit        (in_short_circuit),
    .in_impact_ready         (in_impact_ready),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_overload_signal     (out_overload_signal),
    .out_overload_flag       (out_overload_flag),
    .out_output_high_flag    (out_output_high_flag),
    .out_timeout_flag        (out_timeout_flag),
    .out_impact_flag         (out_impact_flag),
    .out_delay_count         (out_delay_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the shadow state by one loop beat and return the result it owes
  function automatic result_t predict_protection(input item_t b);
    result_t     r;
    int unsigned add;
    logic        sig;
    // output-high confirmation
    if (b.tick_40ms) begin
      if (prot_high) begin
        if (b.output_load_level == '0 && !b.short_circuit) begin
          prot_high = 1'b0;
          prot_high_cnt = 0;
        end
      end else if (b.output_load_level == OUT_LVL_ALL || b.short_circuit) begin
        prot_high_cnt += 2;
        if (prot_high_cnt >= HIGH_CONFIRM_MAX) begin
          prot_high = 1'b1;
          prot_high_cnt = HIGH_CONFIRM_MAX;
        end
      end else begin
        prot_high_cnt = 0;
      end
    end
    // inverter overload confirmation, bypass mirrors the high flag when closed
    if (b.on_inverter) begin
      if (b.tick_40ms) begin
        if (prot_ovl) begin
          if (b.inverter_load_level == '0 && !b.short_circuit) begin
            prot_ovl = 1'b0;
            prot_ovl_cnt = 0;
          end
        end else if (b.inverter_load_level > INV_LVL_OVL || b.short_circuit) begin
          prot_ovl_cnt += b.short_circuit ? 3 : 2;
          if (prot_ovl_cnt >= OVL_CONFIRM_MAX) begin
            prot_ovl = 1'b1;
            prot_ovl_cnt = OVL_CONFIRM_MAX;
          end
        end else begin
          prot_ovl_cnt = 0;
        end
      end
    end else begin
      prot_ovl_cnt = 0;
      prot_ovl = b.bypass_switch_closed ? prot_high : 1'b0;
    end
    // inverse-time accumulator and impact request
    if (b.on_inverter) begin
      if (b.tick_40ms) begin
        if (!prot_ovl) begin
          prot_delay = (prot_delay > prot_cfg.decay_step) ? prot_delay - prot_cfg.decay_step : 0;
        end else begin
          if (b.inverter_load_level == INV_LVL_SEV || b.short_circuit)
            add = prot_cfg.severe_increment;
          else if (b.inverter_load_level == INV_LVL_MED)
            add = prot_cfg.medium_increment;
          else
            add = prot_cfg.light_increment;
          prot_delay += add;
          if (prot_delay >= prot_cfg.timeout_limit) begin
            prot_timeout = 1'b1;
            prot_delay = prot_cfg.timeout_limit;
          end
        end
      end
      if (b.impact_ready) prot_impact = 1'b1;
    end else begin
      prot_timeout = 1'b0;
      prot_delay = 0;
      prot_impact = 1'b0;
    end
    // bus signal, timeout wins over impact, then the hold runs out
    if (prot_timeout) begin
      sig = 1'b1;
      prot_hold = prot_cfg.timeout_hold;
    end else if (prot_impact) begin
      sig = 1'b1;
      prot_hold = prot_cfg.impact_hold;
    end else if (prot_hold > 0) begin
      prot_hold--;
      sig = 1'b1;
    end else begin
      sig = 1'b0;
    end
    r.overload_signal  = sig;
    r.overload_flag    = prot_ovl;
    r.output_high_flag = prot_high;
    r.timeout_flag     = prot_timeout;
    r.impact_flag      = prot_impact;
    r.delay_count      = COUNT_W'(prot_delay);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  function automatic void add_beat(input logic tick, on_inv, bp_closed,
                                   input logic [OUT_LVL_W-1:0] out_lvl,
                                   input logic [INV_LVL_W-1:0] inv_lvl,
                                   input logic sc, impact_ok);
    loop_beats_pending.push_back('{tick, on_inv, bp_closed, out_lvl, inv_lvl, sc, impact_ok});
  endfunction

  // random beats in runs: mostly overload and recovery sequences, some bypass and noise
  task automatic queue_random(input int n);
    int        left;
    int        len;
    int        k;
    int        sev;
    int        pick;
    run_kind_t kind;
    item_t     b;
    @(negedge clk);
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? RUN_OVERLOAD : (pick < 7) ? RUN_RECOVER :
             (pick < 8) ? RUN_BYPASS : RUN_NOISE;
      len = $urandom_range(3, 30);
      if (len > left) len = left;
      sev = $urandom_range(0, 2);
      for (k = 0; k < len; k++) begin
        b = item_t'($bits(item_t)'($urandom));
        if (kind != RUN_NOISE) b.tick_40ms = ($urandom_range(0, 99) < 70);
        case (kind)
          RUN_OVERLOAD: begin
            b.on_inverter = 1'b1;
            if ($urandom_range(0, 3) != 0) b.output_load_level = OUT_LVL_ALL;
            b.inverter_load_level = (sev == 0) ? INV_LVL_SEV : (sev == 1) ? INV_LVL_MED :
                                    INV_LVL_W'($urandom_range(3, 30));
            b.short_circuit = ($urandom_range(0, 99) < 8);
            b.impact_ready = ($urandom_range(0, 99) < 3);
          end
          RUN_RECOVER: begin
            b.on_inverter = 1'b1;
            if ($urandom_range(0, 1) != 0) b.output_load_level = '0;
            b.inverter_load_level = INV_LVL_W'($urandom_range(0, 2));
            b.short_circuit = 1'b0;
            b.impact_ready = ($urandom_range(0, 99) < 2);
          end
          RUN_BYPASS: begin
            b.on_inverter = 1'b0;
            b.short_circuit = ($urandom_range(0, 99) < 10);
          end
          default: ;
        endcase
        loop_beats_pending.push_back(b);
      end
      left -= len;
    end
  endtask

  // wait until every beat is sent and every owed result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (loop_beats_pending.size() != 0 || in_valid || protection_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TIMEOUT_LIMIT:    prot_cfg.timeout_limit    = val[LIMIT_W-1:0];
      REG_SEVERE_INCREMENT: prot_cfg.severe_increment = val[SEVERE_W-1:0];
      REG_MEDIUM_INCREMENT: prot_cfg.medium_increment = val[STEP_W-1:0];
      REG_LIGHT_INCREMENT:  prot_cfg.light_increment  = val[STEP_W-1:0];
      REG_DECAY_STEP:       prot_cfg.decay_step       = val[STEP_W-1:0];
      REG_TIMEOUT_HOLD:     prot_cfg.timeout_hold     = val[HOLD_W-1:0];
      REG_IMPACT_HOLD:      prot_cfg.impact_hold      = val[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // write the whole register set, junk in the unused upper data bits
  task automatic apply_settings(input cfg_t s);
    write_reg(REG_TIMEOUT_LIMIT, s.timeout_limit);
    write_reg(REG_SEVERE_INCREMENT, {(CFG_DATA_W-SEVERE_W)'($urandom), s.severe_increment});
    write_reg(REG_MEDIUM_INCREMENT, {(CFG_DATA_W-STEP_W)'($urandom), s.medium_increment});
    write_reg(REG_LIGHT_INCREMENT, {(CFG_DATA_W-STEP_W)'($urandom), s.light_increment});
    write_reg(REG_DECAY_STEP, {(CFG_DATA_W-STEP_W)'($urandom), s.decay_step});
    write_reg(REG_TIMEOUT_HOLD, {(CFG_DATA_W-HOLD_W)'($urandom), s.timeout_hold});
    write_reg(REG_IMPACT_HOLD, {(CFG_DATA_W-HOLD_W)'($urandom), s.impact_hold});
    settings_used++;
  endtask

  // driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin : drive_beats
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        protection_results_due.push_back(predict_protection(beat_on_offer));
      if (!in_valid || in_ready) begin
        if (loop_beats_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = loop_beats_pending.pop_front();
          in_valid                <= 1'b1;
          beat_on_offer           <= nxt;
          in_tick_40ms            <= nxt.tick_40ms;
          in_on_inverter          <= nxt.on_inverter;
          in_bypass_switch_closed <= nxt.bypass_switch_closed;
          in_output_load_level    <= nxt.output_load_level;
          in_inverter_load_level  <= nxt.inverter_load_level;
          in_short_circuit        <= nxt.short_circuit;
          in_impact_ready         <= nxt.impact_ready;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest owed one
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (protection_results_due.size() == 0) begin
          $error("result beat arrived with nothing owed");
          mismatches++;
        end else begin
          want = protection_results_due.pop_front();
          check_field("overload_signal", want.overload_signal, out_overload_signal);
          check_field("overload_flag", want.overload_flag, out_overload_flag);
          check_field("output_high_flag", want.output_high_flag, out_output_high_flag);
          check_field("timeout_flag", want.timeout_flag, out_timeout_flag);
          check_field("impact_flag", want.impact_flag, out_impact_flag);
          check_field("delay_count", want.delay_count, out_delay_count);
          if (want.timeout_flag) timeouts_seen++;
          if (want.impact_flag) impacts_seen++;
          if (want.overload_signal && !want.timeout_flag && !want.impact_flag) held_seen++;
        end
        results_checked++;
        // long back-pressure so the block fills and stalls its input
        if (results_checked % LONG_HOLD_EVERY == 0) ready_hold_left = LONG_HOLD_CYCLES;
      end
      if (ready_hold_left != 0) begin
        ready_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // stimulus phases
  initial begin : run_phases
    cfg_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: confirmations, timeout, decay, impact, bypass cases
    add_beat(0, 0, 0, '0, '0, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(0, 1, 1, OUT_LVL_ALL, INV_LVL_SEV, 0, 0);
    add_beat(1, 1, 0, OUT_LVL_ALL, INV_LVL_MED, 0, 0);
    add_beat(1, 1, 0, 3'd5, 5'd3, 1, 0);
    add_beat(1, 1, 0, '0, '0, 0, 0);
    add_beat(1, 1, 0, 3'd1, 5'd5, 0, 0);
    add_beat(1, 1, 0, 3'd2, 5'd4, 1, 0);
    add_beat(1, 1, 0, 3'd3, INV_LVL_OVL, 0, 0);
    add_beat(0, 1, 0, '0, '0, 0, 1);
    add_beat(1, 0, 1, '0, '1, 0, 1);
    add_beat(1, 0, 1, OUT_LVL_ALL, '0, 0, 0);
    add_beat(1, 0, 1, OUT_LVL_ALL, '0, 0, 0);
    add_beat(1, 0, 1, OUT_LVL_ALL, '0, 0, 0);
    add_beat(1, 0, 0, OUT_LVL_ALL, '0, 0, 0);
    add_beat(1, 1, 0, '0, 5'd1, 1, 0);
    add_beat(1, 1, 0, '0, '0, 1, 0);
    add_beat(1, 1, 1, 3'd6, 5'd30, 1, 1);
    add_beat(1, 1, 0, 3'd4, 5'd16, 0, 0);
    queue_random(200);
    wait_idle();

    // every register at its maximum, plus a write past the register list
    s = '1;
    apply_settings(s);
    write_reg(REG_OUT_OF_RANGE, CFG_DATA_W'($urandom));
    queue_random(200);
    wait_idle();

    // every register at zero: timeout on the first overloaded tick, no hold
    s = '0;
    apply_settings(s);
    queue_random(150);
    wait_idle();

    // short limits so timeouts come often, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    s.timeout_limit    = LIMIT_W'($urandom_range(1, 4000));
    s.severe_increment = SEVERE_W'($urandom_range(200, 2000));
    s.medium_increment = STEP_W'($urandom_range(50, 400));
    s.light_increment  = STEP_W'($urandom_range(10, 100));
    s.decay_step       = STEP_W'($urandom_range(0, 200));
    s.timeout_hold     = HOLD_W'($urandom_range(0, 40));
    s.impact_hold      = HOLD_W'($urandom_range(0, 40));
    apply_settings(s);
    queue_random(250);
    wait_idle();

    // fully random settings with idling again
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    s = cfg_t'($bits(cfg_t)'({$urandom, $urandom, $urandom}));
    apply_settings(s);
    queue_random(200);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d result beats over %0d register settings", results_checked,
             settings_used);
    $display("timeout set in %0d, impact set in %0d, signal held over in %0d",
             timeouts_seen, impacts_seen, held_seen);
    if (mismatches == 0 && protection_results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
